>>> hw/rtl/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types and constants for the modular linear recurrence block.
// ----------------------------------------------------------------------------
package mlr_pkg;

  localparam int unsigned CoefW   = 32;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned MemRows = 27;

  localparam logic [1:0] BankAcc  = 2'd0;
  localparam logic [1:0] BankBase = 2'd1;
  localparam logic [1:0] BankTmp  = 2'd2;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_INIT = 14'b00000000000010,
    S_RLD  = 14'b00000000000100,
    S_RDX  = 14'b00000000001000,
    S_RDY  = 14'b00000000010000,
    S_LDY  = 14'b00000000100000,
    S_MUL  = 14'b00000001000000,
    S_ACC  = 14'b00000010000000,
    S_CPR  = 14'b00000100000000,
    S_CPW  = 14'b00001000000000,
    S_LOOP = 14'b00010000000000,
    S_SUMR = 14'b00100000000000,
    S_SUMA = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_e;

  // Address of entry (row, col) of a 3x3 matrix bank in the working memory.
  function automatic logic [AddrW-1:0] mat_addr(logic [1:0] bank, logic [1:0] row,
                                                logic [1:0] col);
    logic [AddrW-1:0] a;
    a = AddrW'(bank) * AddrW'(9) + AddrW'(row) * AddrW'(3) + AddrW'(col);
    return a;
  endfunction

endpackage

>>> hw/rtl/modular_linear_recurrence_matpow.sv
// ----------------------------------------------------------------------------
// modular_linear_recurrence_matpow
// Term n of F(n) = a*F(n-1) + b*F(n-2) + c mod m by 3x3 matrix powering.
// ----------------------------------------------------------------------------
// A query word is taken when start_i is high and busy_o is low. The block
// then stays busy until its answer is shown on term_value_o for exactly one
// cycle with done_o high; the receiver cannot hold it off.
// Index one or two, or a zero modulus, shows its answer in the cycle right
// after the query word is taken.
// Otherwise the block reduces the coefficients, then raises the matrix to
// the power n-2 by square-and-multiply. All products run through one
// bit-serial modular multiplier fed from a small working memory of three
// 3x3 banks with a registered read port. A query needs one squaring per
// bit of n-2 above the lowest and one product per set bit.
// Reset returns the sequencer to idle; no query is in flight afterwards.
// ----------------------------------------------------------------------------
module modular_linear_recurrence_matpow #(
  parameter int unsigned INDEX_BITS = 64,
  parameter int unsigned MOD_BITS   = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] coef_a_i,
  input  logic [31:0] coef_b_i,
  input  logic [31:0] coef_c_i,
  input  logic [30:0] modulus_i,
  input  logic [63:0] term_index_i,
  output logic        done_o,
  output logic [30:0] term_value_o
);
  import mlr_pkg::*;

  localparam int unsigned MB = MOD_BITS;
  localparam int unsigned CntW = $clog2(CoefW);

  state_e st_q, st_d;

  logic [INDEX_BITS-1:0] e_q, e_d;
  logic [CoefW-1:0]      ca_q, cb_q, cc_q, ca_d, cb_d, cc_d;
  logic [MB-1:0]         md_q, md_d;
  logic [CoefW-1:0]      xs_q, xs_d;
  logic [MB-1:0]         y_q, y_d;
  logic [MB-1:0]         p_q, p_d;
  logic [MB-1:0]         s_q, s_d;
  logic [MB-1:0]         res_q, res_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [1:0]            r_q, r_d, c_q, c_d, k_q, k_d;
  logic                  sq_q, sq_d;
  logic                  red_q, red_d;

  logic [MB-1:0]    mem_q [MemRows];
  logic [MB-1:0]    rdata_q;
  logic             we, re;
  logic [AddrW-1:0] waddr, raddr;
  logic [MB-1:0]    wdata;

  logic [INDEX_BITS-1:0] n_w;
  logic [MB-1:0]         one_w;
  logic [MB+1:0]         t_w, m1_w, m2_w;
  logic [MB-1:0]         pn_w;
  logic [MB:0]           add_w;
  logic [MB-1:0]         addm_w;
  logic [MB-1:0]         addin_w;
  logic [1:0]            src1_w;
  logic [AddrW-1:0]      ini_w;
  logic [MB-1:0]         inival_w;

  assign n_w    = term_index_i[INDEX_BITS-1:0];
  assign one_w  = {{(MB-1){1'b0}}, (md_q != MB'(1))};
  assign src1_w = sq_q ? BankBase : BankAcc;

  // Bit-serial modular multiply step: p = (2p + bit*y) mod m, with p < m.
  assign m1_w = {2'b00, md_q};
  assign m2_w = {1'b0, md_q, 1'b0};
  assign t_w  = {1'b0, p_q, 1'b0} + (xs_q[CoefW-1] ? {2'b00, y_q} : '0);
  always_comb begin
    if (t_w >= m2_w) begin
      pn_w = MB'(t_w - m2_w);
    end else if (t_w >= m1_w) begin
      pn_w = MB'(t_w - m1_w);
    end else begin
      pn_w = MB'(t_w);
    end
  end

  // Modular add of s and either the last product or a memory word.
  assign addin_w = st_q[6:0] == '0 && st_q == S_SUMA ? rdata_q : p_q;
  assign add_w   = {1'b0, s_q} + {1'b0, addin_w};
  assign addm_w  = (add_w >= {1'b0, md_q}) ? MB'(add_w - {1'b0, md_q}) : MB'(add_w);

  // Initial contents: identity in the acc bank, fixed rows in the base bank.
  assign ini_w = AddrW'(cnt_q);
  always_comb begin
    if (ini_w == AddrW'(0) || ini_w == AddrW'(4) || ini_w == AddrW'(8) ||
        ini_w == AddrW'(12) || ini_w == AddrW'(17)) begin
      inival_w = one_w;
    end else begin
      inival_w = '0;
    end
  end

  always_comb begin
    st_d  = st_q;
    e_d   = e_q;
    ca_d  = ca_q;
    cb_d  = cb_q;
    cc_d  = cc_q;
    md_d  = md_q;
    xs_d  = xs_q;
    y_d   = y_q;
    p_d   = p_q;
    s_d   = s_q;
    res_d = res_q;
    cnt_d = cnt_q;
    r_d   = r_q;
    c_d   = c_q;
    k_d   = k_q;
    sq_d  = sq_q;
    red_d = red_q;
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = '0;
    case (st_q)
      S_IDLE: begin
        if (start_i) begin
          ca_d = coef_a_i;
          cb_d = coef_b_i;
          cc_d = coef_c_i;
          md_d = modulus_i[MB-1:0];
          e_d  = n_w - INDEX_BITS'(2);
          cnt_d = '0;
          if (n_w == INDEX_BITS'(1) || n_w == INDEX_BITS'(2)) begin
            res_d = MB'(1);
            st_d  = S_DONE;
          end else if (modulus_i[MB-1:0] == '0) begin
            res_d = '0;
            st_d  = S_DONE;
          end else begin
            st_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        we    = 1'b1;
        waddr = ini_w;
        wdata = inival_w;
        if (ini_w == AddrW'(17)) begin
          k_d   = '0;
          red_d = 1'b1;
          st_d  = S_RLD;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      S_RLD: begin
        case (k_q)
          2'd0:    xs_d = ca_q;
          2'd1:    xs_d = cb_q;
          default: xs_d = cc_q;
        endcase
        y_d   = one_w;
        p_d   = '0;
        cnt_d = '0;
        st_d  = S_MUL;
      end
      S_RDX: begin
        re    = 1'b1;
        raddr = mat_addr(src1_w, r_q, k_q);
        st_d  = S_RDY;
      end
      S_RDY: begin
        re    = 1'b1;
        raddr = mat_addr(BankBase, k_q, c_q);
        xs_d  = {{(CoefW-MB){1'b0}}, rdata_q};
        st_d  = S_LDY;
      end
      S_LDY: begin
        y_d   = rdata_q;
        p_d   = '0;
        cnt_d = '0;
        st_d  = S_MUL;
      end
      S_MUL: begin
        p_d  = pn_w;
        xs_d = {xs_q[CoefW-2:0], 1'b0};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(CoefW - 1)) begin
          if (red_q) begin
            we    = 1'b1;
            waddr = mat_addr(BankBase, 2'd0, k_q);
            wdata = pn_w;
            if (k_q == 2'd2) begin
              red_d = 1'b0;
              st_d  = S_LOOP;
            end else begin
              k_d  = k_q + 2'd1;
              st_d = S_RLD;
            end
          end else begin
            st_d = S_ACC;
          end
        end
      end
      S_ACC: begin
        st_d = S_RDX;
        if (k_q == 2'd2) begin
          we    = 1'b1;
          waddr = mat_addr(BankTmp, r_q, c_q);
          wdata = addm_w;
          s_d   = '0;
          k_d   = '0;
          if (c_q == 2'd2) begin
            c_d = '0;
            if (r_q == 2'd2) begin
              cnt_d = '0;
              st_d  = S_CPR;
            end else begin
              r_d = r_q + 2'd1;
            end
          end else begin
            c_d = c_q + 2'd1;
          end
        end else begin
          s_d = addm_w;
          k_d = k_q + 2'd1;
        end
      end
      S_CPR: begin
        re    = 1'b1;
        raddr = mat_addr(BankTmp, 2'd0, 2'd0) + AddrW'(cnt_q);
        st_d  = S_CPW;
      end
      S_CPW: begin
        we    = 1'b1;
        waddr = mat_addr(src1_w, 2'd0, 2'd0) + AddrW'(cnt_q);
        wdata = rdata_q;
        if (cnt_q == CntW'(8)) begin
          st_d = S_LOOP;
        end else begin
          cnt_d = cnt_q + CntW'(1);
          st_d  = S_CPR;
        end
      end
      S_LOOP: begin
        r_d = '0;
        c_d = '0;
        k_d = '0;
        s_d = '0;
        if (e_q == '0) begin
          st_d = S_SUMR;
        end else if (e_q[0]) begin
          e_d  = {e_q[INDEX_BITS-1:1], 1'b0};
          sq_d = 1'b0;
          st_d = S_RDX;
        end else begin
          e_d = e_q >> 1;
          if ((e_q >> 1) != '0) begin
            sq_d = 1'b1;
            st_d = S_RDX;
          end
        end
      end
      S_SUMR: begin
        re    = 1'b1;
        raddr = mat_addr(BankAcc, 2'd0, k_q);
        st_d  = S_SUMA;
      end
      S_SUMA: begin
        if (k_q == 2'd2) begin
          res_d = addm_w;
          st_d  = S_DONE;
        end else begin
          s_d  = addm_w;
          k_d  = k_q + 2'd1;
          st_d = S_SUMR;
        end
      end
      S_DONE: begin
        st_d = S_IDLE;
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      red_q <= 1'b0;
      sq_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      red_q <= red_d;
      sq_q  <= sq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q   <= e_d;
    ca_q  <= ca_d;
    cb_q  <= cb_d;
    cc_q  <= cc_d;
    md_q  <= md_d;
    xs_q  <= xs_d;
    y_q   <= y_d;
    p_q   <= p_d;
    s_q   <= s_d;
    res_q <= res_d;
    cnt_q <= cnt_d;
    r_q   <= r_d;
    c_q   <= c_d;
    k_q   <= k_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign busy_o       = (st_q != S_IDLE);
  assign done_o       = (st_q == S_DONE);
  assign term_value_o = 31'(res_q);

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(st_q))
    else $error("sequencer state is not one-hot");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy_o)
    else $error("result word shown while idle");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
                            start_i && !busy_o |=> busy_o)
    else $error("accepted query did not make the block busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy_o)
    else $error("block stayed busy after its result word");
  a_mul_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
                                st_q == S_MUL |-> p_q < md_q)
    else $error("partial product left the residue range");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the matrix-power linear recurrence block. Query
// words come from a queue filled with directed and random cases, and each
// answer is predicted by an independent 3x3 matrix power mod m.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned LimitCycles = 50_000_000;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [30:0] m;
    logic [63:0] n;
    int unsigned gap_pct;
    bit          drain;
  } query_t;

  typedef logic [63:0] mat3_t [3][3];

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] coef_a_i = '0;
  logic [31:0] coef_b_i = '0;
  logic [31:0] coef_c_i = '0;
  logic [30:0] modulus_i = '0;
  logic [63:0] term_index_i = '0;
  logic        done_o;
  logic [30:0] term_value_o;

  query_t      query_q[$];
  logic [30:0] term_q[$];
  int unsigned mismatches = 0;
  longint unsigned cycles = 0;

  modular_linear_recurrence_matpow DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .coef_a_i    (coef_a_i),
    .coef_b_i    (coef_b_i),
    .coef_c_i    (coef_c_i),
    .modulus_i   (modulus_i),
    .term_index_i(term_index_i),
    .done_o      (done_o),
    .term_value_o(term_value_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void mat_mul_mod(ref mat3_t dst, input mat3_t x, input mat3_t y,
                                      input logic [63:0] md);
    logic [63:0] sum;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        sum = 0;
        for (int j = 0; j < 3; j++) begin
          sum = (sum + (x[r][j] * y[j][k]) % md) % md;
        end
        dst[r][k] = sum;
      end
    end
  endfunction

  function automatic logic [30:0] predict_term(query_t q);
    logic [63:0] md, e;
    mat3_t base, pw;
    md = 64'(q.m);
    if (q.n == 64'd1 || q.n == 64'd2) return 31'd1;
    if (md == 0) return 31'd0;
    e = q.n - 64'd2;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        base[r][k] = 0;
        pw[r][k] = (r == k) ? 64'd1 % md : 64'd0;
      end
    end
    base[0][0] = 64'(q.a) % md;
    base[0][1] = 64'(q.b) % md;
    base[0][2] = 64'(q.c) % md;
    base[1][0] = 64'd1 % md;
    base[2][2] = 64'd1 % md;
    while (e != 0) begin
      if (e[0]) mat_mul_mod(pw, pw, base, md);
      e = e >> 1;
      if (e != 0) mat_mul_mod(base, base, base, md);
    end
    return 31'((pw[0][0] + pw[0][1] + pw[0][2]) % md);
  endfunction

  function automatic void add_query(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                    logic [30:0] m, logic [63:0] n,
                                    int unsigned gap_pct, bit drain);
    query_t q;
    q.a = a;
    q.b = b;
    q.c = c;
    q.m = m;
    q.n = n;
    q.gap_pct = gap_pct;
    q.drain = drain;
    query_q.push_back(q);
  endfunction

  // Driver: a word is taken at an edge where start_i is high and busy_o low.
  always @(posedge clk_i) begin
    logic go;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        term_q.push_back(predict_term(query_q.pop_front()));
      end
      go = 1'b0;
      if (query_q.size() != 0) begin
        go = ($urandom_range(99) >= query_q[0].gap_pct);
        if (query_q[0].drain && (term_q.size() != 0 || busy_o ||
                                 (start_i && !busy_o))) begin
          go = 1'b0;
        end
      end
      start_i <= go;
      if (go) begin
        coef_a_i     <= query_q[0].a;
        coef_b_i     <= query_q[0].b;
        coef_c_i     <= query_q[0].c;
        modulus_i    <= query_q[0].m;
        term_index_i <= query_q[0].n;
      end
    end
  end

  // Monitor: each answer is valid for the single cycle done_o is high.
  always @(posedge clk_i) begin
    logic [30:0] want;
    if (rst_ni && done_o) begin
      if (term_q.size() == 0) begin
        $error("unexpected word: term_value actual %0d", term_value_o);
        mismatches++;
      end else begin
        want = term_q.pop_front();
        if (term_value_o !== want) begin
          $error("term_value expected %0d actual %0d", want, term_value_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [63:0] n;
    logic [30:0] m;
    int unsigned sel, gap;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_query(32'd1, 32'd1, 32'd0, 31'd1000, 64'd1, 0, 0);
    add_query(32'd1, 32'd1, 32'd0, 31'd1000, 64'd2, 0, 0);
    add_query(32'd1, 32'd1, 32'd0, 31'd1000, 64'd3, 0, 0);
    add_query(32'd1, 32'd1, 32'd0, 31'd1000000, 64'd40, 0, 0);
    add_query(32'd2, 32'd3, 32'd5, 31'd1, 64'd1, 0, 0);
    add_query(32'd2, 32'd3, 32'd5, 31'd1, 64'd2, 0, 0);
    add_query(32'd2, 32'd3, 32'd5, 31'd1, 64'd17, 0, 0);
    add_query(32'd2, 32'd3, 32'd5, 31'd0, 64'd9, 0, 0);
    add_query(32'd2, 32'd3, 32'd5, 31'd0, 64'd0, 0, 0);
    add_query(32'd2, 32'd3, 32'd5, 31'd0, 64'd2, 0, 0);
    add_query('1, '1, '1, '1, 64'd5, 0, 0);
    add_query('1, '1, '1, '1, '1, 0, 1);
    add_query('1, 32'd0, '1, 31'h7FFF_FFFE, 64'd0, 0, 0);
    add_query(32'd0, 32'd0, 32'd0, 31'd7, 64'd12, 0, 0);
    add_query(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 31'd2, 64'd33, 0, 0);
    add_query(32'h1234_5678, 32'h9ABC_DEF0, 32'd1, 31'h4000_0000,
              64'h5555_5555_5555_5555, 0, 0);

    for (int i = 0; i < 100; i++) begin
      case ((i / 25) % 4)
        0: gap = 0;
        1: gap = 47;
        2: gap = 0;
        default: gap = 26;
      endcase
      sel = $urandom_range(99);
      if (sel < 15) m = 31'($urandom_range(5));
      else if (sel < 50) m = 31'($urandom_range(1000, 2));
      else if (sel < 55) m = 31'h7FFF_FFFF;
      else m = 31'($urandom);
      sel = $urandom_range(99);
      if (i % 33 == 7) n = {$urandom, $urandom};
      else if (sel < 15) n = 64'($urandom_range(2));
      else n = 64'($urandom_range(63, 3));
      add_query($urandom, $urandom, $urandom, m, n, gap, (i == 50));
    end

    while (query_q.size() != 0 || term_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (term_q.size() != 0) begin
      $error("%0d expected words never arrived", term_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/mlr_pkg.sv
hw/rtl/modular_linear_recurrence_matpow.sv
dv/tb_top.sv
